[design/tmse_pkg.sv]
`timescale 1ns / 1ps

package tmse_pkg;

    localparam int RULE_DEPTH = 1024;
    localparam int RULE_AW    = $clog2(RULE_DEPTH);
    localparam int RULE_CW    = $clog2(RULE_DEPTH + 1);
    localparam int TAPE_DEPTH = 128;
    localparam int TAPE_AW    = $clog2(TAPE_DEPTH);
    localparam int TAPE_CW    = $clog2(TAPE_DEPTH + 1);

    localparam int CODE_W = 6;
    localparam int SYM_W  = 8;
    localparam int MOVE_W = 2;

    localparam logic [MOVE_W-1:0] MOVE_RIGHT = 2'd1;
    localparam logic [MOVE_W-1:0] MOVE_LEFT  = 2'd2;

    localparam logic CFG_ACCEPT = 1'b0;
    localparam logic CFG_BLANK  = 1'b1;

    localparam logic [CODE_W-1:0] ACCEPT_RESET = 6'd63;
    localparam logic [SYM_W-1:0]  BLANK_RESET  = 8'd95;

    typedef enum logic [2:0] {
        ACT_CLEAR  = 3'd0,
        ACT_RULE   = 3'd1,
        ACT_APPEND = 3'd2,
        ACT_START  = 3'd3,
        ACT_STEP   = 3'd4,
        ACT_READ   = 3'd5
    } act_t;

    typedef enum logic [2:0] {
        STS_OK          = 3'd0,
        STS_STEPPED     = 3'd1,
        STS_ACCEPTED    = 3'd2,
        STS_HALT        = 3'd3,
        STS_OVERFLOW    = 3'd4,
        STS_NOT_RUNNING = 3'd5
    } sts_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START_RD,
        ST_STEP_RD,
        ST_SCAN,
        ST_EXEC,
        ST_GROW,
        ST_SHIFT,
        ST_READ_RD,
        ST_RESP
    } fsm_t;

    typedef struct packed {
        logic [CODE_W-1:0] nx;
        logic [MOVE_W-1:0] mv;
        logic [SYM_W-1:0]  wr;
        logic [SYM_W-1:0]  rd;
        logic [CODE_W-1:0] st;
    } rule_t;

    typedef struct packed {
        logic               we;
        logic [RULE_AW-1:0] waddr;
        rule_t              wdata;
        logic [RULE_AW-1:0] raddr;
    } rule_req_t;

    typedef struct packed {
        logic               we;
        logic [TAPE_AW-1:0] waddr;
        logic [SYM_W-1:0]   wdata;
        logic [TAPE_AW-1:0] raddr;
    } tape_req_t;

endpackage

[design/turing_machine_step_engine.sv]
`timescale 1ns / 1ps
// flow: clear, add rule, append and unused actions go straight to the response; start and read
//   first read a memory; step reads the tape cell, then scans the rules from index 0, one rule
//   compared per cycle on the rule store read port, then executes, then a left-edge shift
//   moves every cell through the tape port or a right-edge growth adds one cell
// throughput: one request at a time, next request taken once the result is registered
// reset: asynchronous active low, clears rule count, tape length, head, state and running, config to 63 / 95

module turing_machine_step_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // rule_state, rule_read, rule_write, rule_move, rule_next, tape_symbol, tape_position
    input  logic [47:0] s_axis_tdata,
    // action
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // machine_state, head_index, tape_used, cell_value, fired_rule
    output logic [39:0] m_axis_tdata,
    // status
    output logic [2:0]  m_axis_tuser,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int RAW = tmse_pkg::RULE_AW;
    localparam int RCW = tmse_pkg::RULE_CW;
    localparam int TAW = tmse_pkg::TAPE_AW;
    localparam int TCW = tmse_pkg::TAPE_CW;
    localparam int CW  = tmse_pkg::CODE_W;
    localparam int SW  = tmse_pkg::SYM_W;

    tmse_pkg::fsm_t state_reg, state_next;
    tmse_pkg::act_t act_in;

    logic [CW-1:0]  accept_reg, accept_next;
    logic [SW-1:0]  blank_reg, blank_next;
    logic [RCW-1:0] rule_total_reg, rule_total_next;
    logic [TCW-1:0] tape_len_reg, tape_len_next;
    logic [TAW-1:0] head_reg, head_next;
    logic [CW-1:0]  code_reg, code_next;
    logic           running_reg, running_next;
    logic [SW-1:0]  under_reg, under_next;
    logic [RCW-1:0] scan_addr_reg, scan_addr_next;
    logic           cmp_valid_reg, cmp_valid_next;
    logic [RAW-1:0] cmp_idx_reg, cmp_idx_next;
    tmse_pkg::rule_t rule_reg, rule_next;
    logic [RAW-1:0] fired_reg, fired_next;
    tmse_pkg::sts_t status_reg, status_next;
    logic [SW-1:0]  cell_reg, cell_next;
    logic [TAW-1:0] pos_reg, pos_next;
    logic [TCW-1:0] shift_cnt_reg, shift_cnt_next;
    logic           shift_pend_reg, shift_pend_next;
    logic [TAW-1:0] shift_wa_reg, shift_wa_next;
    logic           m_valid_reg, m_valid_next;
    logic [39:0]    m_data_reg, m_data_next;
    logic [2:0]     m_user_reg, m_user_next;

    tmse_pkg::rule_req_t rule_req;
    tmse_pkg::tape_req_t tape_req;
    tmse_pkg::rule_t     rule_rdata;
    logic                rule_hit;
    logic [SW-1:0]       tape_rdata;

    tmse_pkg::rule_t in_rule;
    logic [SW-1:0]   in_sym;
    logic [TAW-1:0]  in_pos;
    logic            accept_in;
    logic            scan_hit;
    logic            edge_l;
    logic            edge_r;
    logic [TCW-1:0]  head_plus;
    logic            out_free;

    assign act_in      = tmse_pkg::act_t'(s_axis_tuser);
    assign in_rule.st  = s_axis_tdata[5:0];
    assign in_rule.rd  = s_axis_tdata[13:6];
    assign in_rule.wr  = s_axis_tdata[21:14];
    assign in_rule.mv  = s_axis_tdata[23:22];
    assign in_rule.nx  = s_axis_tdata[29:24];
    assign in_sym      = s_axis_tdata[37:30];
    assign in_pos      = s_axis_tdata[44:38];

    assign s_axis_tready = (state_reg == tmse_pkg::ST_IDLE);
    assign accept_in     = s_axis_tvalid && s_axis_tready;
    assign scan_hit      = cmp_valid_reg && rule_hit;
    assign head_plus     = {1'b0, head_reg} + 1'b1;
    assign edge_l        = (rule_reg.mv == tmse_pkg::MOVE_LEFT) && (head_reg == '0);
    assign edge_r        = (rule_reg.mv == tmse_pkg::MOVE_RIGHT) && (head_plus >= tape_len_reg);
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    tmse_rule_unit u_rules (
        .clk   (clk),
        .req   (rule_req),
        .code  (code_reg),
        .under (under_reg),
        .rdata (rule_rdata),
        .hit   (rule_hit)
    );

    tmse_tape_ram u_tape (
        .clk   (clk),
        .req   (tape_req),
        .rdata (tape_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tmse_pkg::ST_IDLE:
            begin
                if (accept_in)
                begin
                    unique case (act_in)
                        tmse_pkg::ACT_START: state_next = tmse_pkg::ST_START_RD;
                        tmse_pkg::ACT_STEP:
                            state_next = running_reg ? tmse_pkg::ST_STEP_RD : tmse_pkg::ST_RESP;
                        tmse_pkg::ACT_READ:  state_next = tmse_pkg::ST_READ_RD;
                        default:             state_next = tmse_pkg::ST_RESP;
                    endcase
                end
            end
            tmse_pkg::ST_START_RD: state_next = tmse_pkg::ST_RESP;
            tmse_pkg::ST_STEP_RD:  state_next = tmse_pkg::ST_SCAN;
            tmse_pkg::ST_SCAN:
            begin
                priority if (scan_hit)
                    state_next = tmse_pkg::ST_EXEC;
                else if (scan_addr_reg >= rule_total_reg)
                    state_next = tmse_pkg::ST_RESP;
            end
            tmse_pkg::ST_EXEC:
            begin
                priority if ((edge_l || edge_r) && (tape_len_reg >= TCW'(tmse_pkg::TAPE_DEPTH)))
                    state_next = tmse_pkg::ST_RESP;
                else if (edge_r)
                    state_next = tmse_pkg::ST_GROW;
                else if (edge_l)
                    state_next = tmse_pkg::ST_SHIFT;
                else
                    state_next = tmse_pkg::ST_RESP;
            end
            tmse_pkg::ST_GROW: state_next = tmse_pkg::ST_RESP;
            tmse_pkg::ST_SHIFT:
            begin
                if ((shift_cnt_reg == '0) && !shift_pend_reg)
                    state_next = tmse_pkg::ST_RESP;
            end
            tmse_pkg::ST_READ_RD: state_next = tmse_pkg::ST_RESP;
            tmse_pkg::ST_RESP:
            begin
                if (out_free)
                    state_next = tmse_pkg::ST_IDLE;
            end
            default: state_next = tmse_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory requests
    always_comb
    begin
        accept_next     = accept_reg;
        blank_next      = blank_reg;
        rule_total_next = rule_total_reg;
        tape_len_next   = tape_len_reg;
        head_next       = head_reg;
        code_next       = code_reg;
        running_next    = running_reg;
        under_next      = under_reg;
        scan_addr_next  = scan_addr_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        rule_next       = rule_reg;
        fired_next      = fired_reg;
        status_next     = status_reg;
        cell_next       = cell_reg;
        pos_next        = pos_reg;
        shift_cnt_next  = shift_cnt_reg;
        shift_pend_next = shift_pend_reg;
        shift_wa_next   = shift_wa_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;

        rule_req.we    = 1'b0;
        rule_req.waddr = rule_total_reg[RAW-1:0];
        rule_req.wdata = in_rule;
        rule_req.raddr = scan_addr_reg[RAW-1:0];
        tape_req.we    = 1'b0;
        tape_req.waddr = head_reg;
        tape_req.wdata = rule_reg.wr;
        tape_req.raddr = head_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                tmse_pkg::CFG_ACCEPT: accept_next = cfg_data[CW-1:0];
                tmse_pkg::CFG_BLANK:  blank_next  = cfg_data;
                default:              blank_next  = blank_reg;
            endcase
        end

        unique case (state_reg)
            tmse_pkg::ST_IDLE:
            begin
                if (accept_in)
                begin
                    status_next = tmse_pkg::STS_OK;
                    cell_next   = '0;
                    fired_next  = '0;
                    pos_next    = in_pos;
                    unique case (act_in)
                        tmse_pkg::ACT_CLEAR:
                        begin
                            rule_total_next = '0;
                            tape_len_next   = '0;
                            head_next       = '0;
                            code_next       = '0;
                            running_next    = 1'b0;
                        end
                        tmse_pkg::ACT_RULE:
                        begin
                            if (rule_total_reg >= RCW'(tmse_pkg::RULE_DEPTH))
                            begin
                                status_next = tmse_pkg::STS_OVERFLOW;
                            end
                            else
                            begin
                                rule_req.we     = 1'b1;
                                rule_total_next = rule_total_reg + 1'b1;
                            end
                        end
                        tmse_pkg::ACT_APPEND:
                        begin
                            if (tape_len_reg >= TCW'(tmse_pkg::TAPE_DEPTH))
                            begin
                                status_next = tmse_pkg::STS_OVERFLOW;
                            end
                            else
                            begin
                                tape_req.we    = 1'b1;
                                tape_req.waddr = tape_len_reg[TAW-1:0];
                                tape_req.wdata = in_sym;
                                cell_next      = in_sym;
                                tape_len_next  = tape_len_reg + 1'b1;
                            end
                        end
                        tmse_pkg::ACT_START:
                        begin
                            rule_req.raddr = '0;
                            head_next      = '0;
                            running_next   = 1'b1;
                            if (tape_len_reg == '0)
                            begin
                                tape_req.we    = 1'b1;
                                tape_req.waddr = '0;
                                tape_req.wdata = blank_reg;
                                tape_len_next  = TCW'(1);
                            end
                        end
                        tmse_pkg::ACT_STEP:
                        begin
                            tape_req.raddr = head_reg;
                            if (!running_reg)
                                status_next = tmse_pkg::STS_NOT_RUNNING;
                        end
                        tmse_pkg::ACT_READ:
                        begin
                            tape_req.raddr = in_pos;
                        end
                        default:
                        begin
                            status_next = tmse_pkg::STS_OK;
                        end
                    endcase
                end
            end
            tmse_pkg::ST_START_RD:
            begin
                code_next = (rule_total_reg != '0) ? rule_rdata.st : '0;
            end
            tmse_pkg::ST_STEP_RD:
            begin
                under_next     = ({1'b0, head_reg} < tape_len_reg) ? tape_rdata : blank_reg;
                scan_addr_next = '0;
            end
            tmse_pkg::ST_SCAN:
            begin
                priority if (scan_hit)
                begin
                    rule_next  = rule_rdata;
                    fired_next = cmp_idx_reg;
                end
                else if (scan_addr_reg >= rule_total_reg)
                begin
                    running_next = 1'b0;
                    status_next  = tmse_pkg::STS_HALT;
                end
                else
                begin
                    // one rule read per cycle, compared as its data returns
                    rule_req.raddr = scan_addr_reg[RAW-1:0];
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_addr_reg[RAW-1:0];
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
            end
            tmse_pkg::ST_EXEC:
            begin
                if ((edge_l || edge_r) && (tape_len_reg >= TCW'(tmse_pkg::TAPE_DEPTH)))
                begin
                    running_next = 1'b0;
                    status_next  = tmse_pkg::STS_OVERFLOW;
                    fired_next   = '0;
                end
                else
                begin
                    tape_req.we    = 1'b1;
                    tape_req.waddr = head_reg;
                    tape_req.wdata = rule_reg.wr;
                    code_next      = rule_reg.nx;
                    cell_next      = rule_reg.wr;
                    if (rule_reg.nx == accept_reg)
                    begin
                        running_next = 1'b0;
                        status_next  = tmse_pkg::STS_ACCEPTED;
                    end
                    else
                    begin
                        status_next = tmse_pkg::STS_STEPPED;
                    end
                    if ((rule_reg.mv == tmse_pkg::MOVE_RIGHT) && !edge_r)
                        head_next = head_reg + 1'b1;
                    if ((rule_reg.mv == tmse_pkg::MOVE_LEFT) && !edge_l)
                        head_next = head_reg - 1'b1;
                    shift_cnt_next  = tape_len_reg;
                    shift_pend_next = 1'b0;
                end
            end
            tmse_pkg::ST_GROW:
            begin
                tape_req.we    = 1'b1;
                tape_req.waddr = tape_len_reg[TAW-1:0];
                tape_req.wdata = blank_reg;
                tape_len_next  = tape_len_reg + 1'b1;
                head_next      = tape_len_reg[TAW-1:0];
            end
            tmse_pkg::ST_SHIFT:
            begin
                // move every cell up by one, highest first, then blank at cell 0
                if (shift_pend_reg)
                begin
                    tape_req.we    = 1'b1;
                    tape_req.waddr = shift_wa_reg;
                    tape_req.wdata = tape_rdata;
                end
                else if (shift_cnt_reg == '0)
                begin
                    tape_req.we    = 1'b1;
                    tape_req.waddr = '0;
                    tape_req.wdata = blank_reg;
                    tape_len_next  = tape_len_reg + 1'b1;
                end
                if (shift_cnt_reg != '0)
                begin
                    tape_req.raddr  = TAW'(shift_cnt_reg - 1'b1);
                    shift_wa_next   = shift_cnt_reg[TAW-1:0];
                    shift_cnt_next  = shift_cnt_reg - 1'b1;
                    shift_pend_next = 1'b1;
                end
                else
                begin
                    shift_pend_next = 1'b0;
                end
            end
            tmse_pkg::ST_READ_RD:
            begin
                cell_next = ({1'b0, pos_reg} < tape_len_reg) ? tape_rdata : blank_reg;
            end
            tmse_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, fired_reg, cell_reg, tape_len_reg, head_reg, code_reg};
                    m_user_next  = status_reg;
                end
            end
            default:
            begin
                cmp_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tmse_pkg::ST_IDLE;
            accept_reg     <= tmse_pkg::ACCEPT_RESET;
            blank_reg      <= tmse_pkg::BLANK_RESET;
            rule_total_reg <= '0;
            tape_len_reg   <= '0;
            head_reg       <= '0;
            code_reg       <= '0;
            running_reg    <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            shift_pend_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            accept_reg     <= accept_next;
            blank_reg      <= blank_next;
            rule_total_reg <= rule_total_next;
            tape_len_reg   <= tape_len_next;
            head_reg       <= head_next;
            code_reg       <= code_next;
            running_reg    <= running_next;
            cmp_valid_reg  <= cmp_valid_next;
            shift_pend_reg <= shift_pend_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        under_reg     <= under_next;
        scan_addr_reg <= scan_addr_next;
        cmp_idx_reg   <= cmp_idx_next;
        rule_reg      <= rule_next;
        fired_reg     <= fired_next;
        status_reg    <= status_next;
        cell_reg      <= cell_next;
        pos_reg       <= pos_next;
        shift_cnt_reg <= shift_cnt_next;
        shift_wa_reg  <= shift_wa_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

    a_running_has_tape: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (tape_len_reg != '0))
        else $error("machine running on an empty tape");

    a_head_in_tape: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> ({1'b0, head_reg} < tape_len_reg))
        else $error("head beyond the used tape while running");

    a_tape_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tape_len_reg <= TCW'(tmse_pkg::TAPE_DEPTH))
        else $error("tape length beyond tape depth");

    a_rule_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rule_total_reg <= RCW'(tmse_pkg::RULE_DEPTH))
        else $error("rule count beyond rule depth");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("new request taken before the last one finished");

endmodule

[design/tmse_rule_unit.sv]
`timescale 1ns / 1ps

module tmse_rule_unit (
    input  logic                           clk,
    input  tmse_pkg::rule_req_t            req,
    input  logic [tmse_pkg::CODE_W-1:0]    code,
    input  logic [tmse_pkg::SYM_W-1:0]     under,
    output tmse_pkg::rule_t                rdata,
    output logic                           hit
);

    tmse_pkg::rule_t rule_mem [tmse_pkg::RULE_DEPTH];
    tmse_pkg::rule_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            rule_mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= rule_mem[req.raddr];
    end

    // shared match compare on the rule just read
    assign hit   = (rdata_reg.st == code) && (rdata_reg.rd == under);
    assign rdata = rdata_reg;

endmodule

[design/tmse_tape_ram.sv]
`timescale 1ns / 1ps

module tmse_tape_ram (
    input  logic                         clk,
    input  tmse_pkg::tape_req_t          req,
    output logic [tmse_pkg::SYM_W-1:0]   rdata
);

    logic [tmse_pkg::SYM_W-1:0] tape_mem [tmse_pkg::TAPE_DEPTH];
    logic [tmse_pkg::SYM_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            tape_mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= tape_mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

[bench/turing_machine_step_engine_tb.sv]
`timescale 1ns / 1ps

module turing_machine_step_engine_tb;

    localparam logic [2:0]                  ACT_SPARE_A = 3'd6;
    localparam logic [2:0]                  ACT_SPARE_B = 3'd7;
    localparam logic [tmse_pkg::MOVE_W-1:0] MOVE_STAY   = 2'd0;
    localparam logic [tmse_pkg::MOVE_W-1:0] MOVE_SPARE  = 2'd3;
    localparam int                          HOLD_CYCLES = 80;

    typedef struct {
        logic [2:0]                  action;
        logic [tmse_pkg::CODE_W-1:0] rule_state;
        logic [tmse_pkg::SYM_W-1:0]  rule_read;
        logic [tmse_pkg::SYM_W-1:0]  rule_write;
        logic [tmse_pkg::MOVE_W-1:0] rule_move;
        logic [tmse_pkg::CODE_W-1:0] rule_next;
        logic [tmse_pkg::SYM_W-1:0]  tape_symbol;
        logic [6:0]                  tape_position;
    } tm_req_t;

    typedef struct {
        logic [2:0]                  status;
        logic [tmse_pkg::CODE_W-1:0] machine_state;
        logic [6:0]                  head_index;
        logic [7:0]                  tape_used;
        logic [tmse_pkg::SYM_W-1:0]  cell_value;
        logic [9:0]                  fired;
    } tm_reply_t;

    class tm_shadow;
        tmse_pkg::rule_t             rules[tmse_pkg::RULE_DEPTH];
        int unsigned                 rule_count;
        logic [tmse_pkg::SYM_W-1:0]  cells[tmse_pkg::TAPE_DEPTH];
        int unsigned                 tape_len;
        int unsigned                 head;
        logic [tmse_pkg::CODE_W-1:0] code;
        bit                          running;
        logic [tmse_pkg::CODE_W-1:0] accept_code;
        logic [tmse_pkg::SYM_W-1:0]  blank_sym;
        tm_reply_t                   expected_replies[$];
        int                          mismatches;
        int                          n_requests;
        int                          n_steps;
        int                          n_accepts;
        int                          n_halts;
        int                          n_overflows;

        function new();
            wipe();
            accept_code = tmse_pkg::ACCEPT_RESET;
            blank_sym   = tmse_pkg::BLANK_RESET;
            mismatches  = 0;
            n_requests  = 0;
            n_steps     = 0;
            n_accepts   = 0;
            n_halts     = 0;
            n_overflows = 0;
        endfunction

        function void wipe();
            rule_count = 0;
            foreach (cells[i])
                cells[i] = '0;
            tape_len = 0;
            head     = 0;
            code     = '0;
            running  = 1'b0;
        endfunction

        function void set_register(logic idx, logic [7:0] value);
            if (idx == tmse_pkg::CFG_ACCEPT)
                accept_code = value[tmse_pkg::CODE_W-1:0];
            else
                blank_sym = value;
        endfunction

        function void run_step(inout tm_reply_t rep);
            int unsigned                i;
            int                         k;
            logic [tmse_pkg::SYM_W-1:0] under;
            tmse_pkg::rule_t            r;
            bit                         found;
            bit                         grow;
            if (!running)
            begin
                rep.status = tmse_pkg::STS_NOT_RUNNING;
                return;
            end
            under = (head < tape_len) ? cells[head] : blank_sym;
            found = 1'b0;
            for (i = 0; i < rule_count; i++)
            begin
                if (rules[i].st == code && rules[i].rd == under)
                begin
                    found = 1'b1;
                    break;
                end
            end
            if (!found)
            begin
                running    = 1'b0;
                rep.status = tmse_pkg::STS_HALT;
                return;
            end
            r    = rules[i];
            grow = (r.mv == tmse_pkg::MOVE_LEFT && head == 0) ||
                   (r.mv == tmse_pkg::MOVE_RIGHT && head + 1 >= tape_len);
            if (grow && tape_len >= tmse_pkg::TAPE_DEPTH)
            begin
                running    = 1'b0;
                rep.status = tmse_pkg::STS_OVERFLOW;
                return;
            end
            cells[head] = r.wr;
            if (r.mv == tmse_pkg::MOVE_RIGHT)
            begin
                head++;
                if (head >= tape_len)
                begin
                    cells[tape_len] = blank_sym;
                    tape_len++;
                    head = tape_len - 1;
                end
            end
            else if (r.mv == tmse_pkg::MOVE_LEFT)
            begin
                if (head == 0)
                begin
                    for (k = tape_len; k > 0; k--)
                        cells[k] = cells[k-1];
                    cells[0] = blank_sym;
                    tape_len++;
                end
                else
                    head--;
            end
            code           = r.nx;
            rep.cell_value = r.wr;
            rep.fired      = 10'(i);
            if (code == accept_code)
            begin
                running    = 1'b0;
                rep.status = tmse_pkg::STS_ACCEPTED;
            end
            else
                rep.status = tmse_pkg::STS_STEPPED;
        endfunction

        function void note_request(tm_req_t q);
            tm_reply_t   rep;
            int unsigned pos;
            rep = '{default: '0};
            case (q.action)
                tmse_pkg::ACT_CLEAR:
                    wipe();
                tmse_pkg::ACT_RULE:
                begin
                    if (rule_count >= tmse_pkg::RULE_DEPTH)
                        rep.status = tmse_pkg::STS_OVERFLOW;
                    else
                    begin
                        rules[rule_count] = '{nx: q.rule_next, mv: q.rule_move,
                                              wr: q.rule_write, rd: q.rule_read,
                                              st: q.rule_state};
                        rule_count++;
                    end
                end
                tmse_pkg::ACT_APPEND:
                begin
                    if (tape_len >= tmse_pkg::TAPE_DEPTH)
                        rep.status = tmse_pkg::STS_OVERFLOW;
                    else
                    begin
                        cells[tape_len] = q.tape_symbol;
                        rep.cell_value  = q.tape_symbol;
                        tape_len++;
                    end
                end
                tmse_pkg::ACT_START:
                begin
                    code = (rule_count > 0) ? rules[0].st : '0;
                    head = 0;
                    if (tape_len == 0)
                    begin
                        cells[0] = blank_sym;
                        tape_len = 1;
                    end
                    running = 1'b1;
                end
                tmse_pkg::ACT_STEP:
                begin
                    run_step(rep);
                    n_steps++;
                end
                tmse_pkg::ACT_READ:
                begin
                    pos = q.tape_position;
                    rep.cell_value = (pos < tape_len) ? cells[pos] : blank_sym;
                end
                default: ;
            endcase
            rep.machine_state = code;
            rep.head_index    = 7'(head);
            rep.tape_used     = 8'(tape_len);
            n_requests++;
            if (rep.status == tmse_pkg::STS_ACCEPTED)
                n_accepts++;
            if (rep.status == tmse_pkg::STS_HALT)
                n_halts++;
            if (rep.status == tmse_pkg::STS_OVERFLOW)
                n_overflows++;
            expected_replies.push_back(rep);
        endfunction

        function void check_reply(tm_reply_t got);
            tm_reply_t want;
            if (expected_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("reply with nothing pending: status %0d state %0d head %0d",
                             got.status, got.machine_state, got.head_index);
                return;
            end
            want = expected_replies.pop_front();
            if (got.status !== want.status || got.machine_state !== want.machine_state ||
                got.head_index !== want.head_index || got.tape_used !== want.tape_used ||
                got.cell_value !== want.cell_value || got.fired !== want.fired)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"reply mismatch: expected sts %0d st %0d head %0d used %0d ",
                              "cell %0d rule %0d, got sts %0d st %0d head %0d used %0d ",
                              "cell %0d rule %0d"},
                             want.status, want.machine_state, want.head_index, want.tape_used,
                             want.cell_value, want.fired, got.status, got.machine_state,
                             got.head_index, got.tape_used, got.cell_value, got.fired);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    tm_shadow shadow;
    int       sent_count;
    int       gap_pct;
    int       stall_pct;
    bit       long_hold;
    bit       pressure_done;

    turing_machine_step_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #10000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic tm_req_t noise_request();
        tm_req_t r;
        r.action        = 3'($urandom_range(0, 7));
        r.rule_state    = 6'($urandom);
        r.rule_read     = 8'($urandom);
        r.rule_write    = 8'($urandom);
        r.rule_move     = 2'($urandom);
        r.rule_next     = 6'($urandom);
        r.tape_symbol   = 8'($urandom);
        r.tape_position = 7'($urandom);
        return r;
    endfunction

    function automatic tm_req_t cmd(logic [2:0] act);
        tm_req_t r;
        r = noise_request();
        r.action = act;
        return r;
    endfunction

    function automatic tm_req_t rule_req(logic [5:0] st, logic [7:0] rd, logic [7:0] wr,
                                         logic [1:0] mv, logic [5:0] nx);
        tm_req_t r;
        r = cmd(tmse_pkg::ACT_RULE);
        r.rule_state = st;
        r.rule_read  = rd;
        r.rule_write = wr;
        r.rule_move  = mv;
        r.rule_next  = nx;
        return r;
    endfunction

    function automatic tm_req_t append_req(logic [7:0] sym);
        tm_req_t r;
        r = cmd(tmse_pkg::ACT_APPEND);
        r.tape_symbol = sym;
        return r;
    endfunction

    function automatic tm_req_t read_req(logic [6:0] pos);
        tm_req_t r;
        r = cmd(tmse_pkg::ACT_READ);
        r.tape_position = pos;
        return r;
    endfunction

    // data: rule_state, rule_read, rule_write, rule_move, rule_next, tape_symbol, tape_position
    function automatic logic [47:0] pack_request(tm_req_t q);
        return {3'b000, q.tape_position, q.tape_symbol, q.rule_next, q.rule_move,
                q.rule_write, q.rule_read, q.rule_state};
    endfunction

    function automatic tm_reply_t unpack_reply(logic [39:0] d, logic [2:0] u);
        tm_reply_t rep;
        rep.status        = u;
        rep.machine_state = d[5:0];
        rep.head_index    = d[12:6];
        rep.tape_used     = d[20:13];
        rep.cell_value    = d[28:21];
        rep.fired         = d[38:29];
        return rep;
    endfunction

    task automatic send_request(tm_req_t q);
        @(negedge clk);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = pack_request(q);
        s_axis_tuser  = q.action;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        shadow.note_request(q);
        sent_count++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (shadow.expected_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(logic idx, logic [7:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        cfg_data  = 8'(~value);
        shadow.set_register(idx, value);
    endtask

    // well-formed programs with random content, some noise and stray requests
    task automatic run_programs(int quota, int calm_from, bit with_pressure);
        logic [7:0] alpha[3];
        int         n;
        int         pick;
        int         hold_at;
        hold_at = sent_count + 60;
        while (sent_count < quota)
        begin
            if (sent_count >= calm_from)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = (($urandom_range(0, 3) == 0) ? 0 : 25);
                stall_pct = (($urandom_range(0, 3) == 0) ? 0 : 25);
            end
            if (with_pressure && !pressure_done && sent_count >= hold_at)
            begin
                long_hold     = 1'b1;
                pressure_done = 1'b1;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 4)) send_request(noise_request());
                continue;
            end
            if ($urandom_range(0, 3) != 0)
                send_request(cmd(tmse_pkg::ACT_CLEAR));
            alpha[0] = shadow.blank_sym;
            alpha[1] = 8'($urandom);
            alpha[2] = 8'($urandom);
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
            repeat (n) send_request(append_req(alpha[$urandom_range(0, 2)]));
            n = $urandom_range(1, 10);
            repeat (n)
                send_request(rule_req(6'($urandom_range(0, 4)), alpha[$urandom_range(0, 2)],
                                      ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                                  : alpha[$urandom_range(0, 2)],
                                      2'($urandom_range(0, 3)),
                                      ($urandom_range(0, 5) == 0) ? shadow.accept_code
                                                                  : 6'($urandom_range(0, 4))));
            send_request(cmd(tmse_pkg::ACT_START));
            n = $urandom_range(1, 25);
            repeat (n)
            begin
                pick = $urandom_range(0, 29);
                if (pick == 0)
                    send_request(read_req(7'($urandom)));
                else if (pick == 1)
                    send_request(read_req(7'($urandom_range(0, 6))));
                else if (pick == 2)
                    send_request(append_req(alpha[$urandom_range(0, 2)]));
                else if (pick == 3)
                    send_request(rule_req(6'($urandom_range(0, 4)), alpha[$urandom_range(0, 2)],
                                          8'($urandom), 2'($urandom), 6'($urandom_range(0, 4))));
                else if (pick == 4)
                    send_request(cmd(($urandom_range(0, 1) == 0) ? ACT_SPARE_A : ACT_SPARE_B));
                else if (pick == 5)
                    send_request(cmd(tmse_pkg::ACT_START));
                else
                    send_request(cmd(tmse_pkg::ACT_STEP));
            end
        end
    endtask

    // receiving side: short random stalls, one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                long_hold = 1'b0;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(negedge clk);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            shadow.check_reply(unpack_reply(m_axis_tdata, m_axis_tuser));
    end

    initial
    begin
        shadow        = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_we        = 1'b0;
        cfg_index     = 1'b0;
        cfg_data      = '0;
        sent_count    = 0;
        gap_pct       = 30;
        stall_pct     = 30;
        long_hold     = 1'b0;
        pressure_done = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, accept 63 and blank 95
        send_request(cmd(tmse_pkg::ACT_STEP));
        send_request(read_req(7'd127));
        send_request(cmd(tmse_pkg::ACT_START));
        send_request(cmd(tmse_pkg::ACT_STEP));
        send_request(cmd(tmse_pkg::ACT_CLEAR));
        send_request(append_req(8'd0));
        send_request(append_req(8'd255));
        send_request(rule_req(6'd0, 8'd0, 8'd255, tmse_pkg::MOVE_RIGHT, 6'd1));
        send_request(rule_req(6'd1, 8'd255, 8'd0, tmse_pkg::MOVE_RIGHT, 6'd2));
        send_request(rule_req(6'd2, 8'd95, 8'd170, MOVE_SPARE, 6'd3));
        send_request(rule_req(6'd3, 8'd170, 8'd85, tmse_pkg::MOVE_LEFT, 6'd4));
        send_request(rule_req(6'd4, 8'd0, 8'd1, tmse_pkg::MOVE_LEFT, 6'd5));
        send_request(rule_req(6'd5, 8'd255, 8'd2, tmse_pkg::MOVE_LEFT, 6'd63));
        send_request(cmd(tmse_pkg::ACT_START));
        repeat (7) send_request(cmd(tmse_pkg::ACT_STEP));
        send_request(read_req(7'd0));
        send_request(read_req(7'd3));
        send_request(cmd(ACT_SPARE_A));
        send_request(cmd(ACT_SPARE_B));
        send_request(rule_req(6'd63, 8'd255, 8'd255, MOVE_SPARE, 6'd63));
        wait_idle();

        // upper bits of the accept write are dropped
        write_register(tmse_pkg::CFG_ACCEPT, 8'hC0);
        write_register(tmse_pkg::CFG_BLANK, 8'd255);
        run_programs(sent_count + 200, 32'h7fffffff, 1'b1);
        wait_idle();

        // full tape: left edge growth fills it, then a left edge growth with no room
        gap_pct   = 20;
        stall_pct = 20;
        write_register(tmse_pkg::CFG_ACCEPT, 8'd62);
        write_register(tmse_pkg::CFG_BLANK, 8'd90);
        send_request(cmd(tmse_pkg::ACT_CLEAR));
        repeat (tmse_pkg::TAPE_DEPTH - 1) send_request(append_req(8'd7));
        send_request(rule_req(6'd0, 8'd7, 8'd4, tmse_pkg::MOVE_LEFT, 6'd1));
        send_request(rule_req(6'd1, 8'd90, 8'd90, tmse_pkg::MOVE_LEFT, 6'd0));
        send_request(cmd(tmse_pkg::ACT_START));
        send_request(cmd(tmse_pkg::ACT_STEP));
        send_request(cmd(tmse_pkg::ACT_STEP));
        send_request(append_req(8'd3));
        send_request(read_req(7'd127));
        send_request(read_req(7'd1));
        send_request(cmd(tmse_pkg::ACT_STEP));
        wait_idle();

        // longer rule scan: decoys ahead of the matching rules, then a halt over all
        write_register(tmse_pkg::CFG_BLANK, 8'd32);
        send_request(cmd(tmse_pkg::ACT_CLEAR));
        send_request(rule_req(6'd1, 8'd32, 8'd32, MOVE_STAY, 6'd2));
        repeat (40)
            send_request(rule_req(6'($urandom_range(3, 63)), 8'($urandom), 8'($urandom),
                                  2'($urandom), 6'($urandom)));
        send_request(rule_req(6'd2, 8'd32, 8'd200, MOVE_STAY, 6'd2));
        send_request(rule_req(6'd2, 8'd200, 8'd1, MOVE_STAY, 6'd2));
        send_request(cmd(tmse_pkg::ACT_START));
        repeat (4) send_request(cmd(tmse_pkg::ACT_STEP));
        send_request(cmd(tmse_pkg::ACT_START));
        send_request(cmd(tmse_pkg::ACT_STEP));
        wait_idle();

        write_register(tmse_pkg::CFG_ACCEPT, 8'd63);
        write_register(tmse_pkg::CFG_BLANK, 8'd0);
        run_programs(sent_count + 150, sent_count + 90, 1'b0);
        wait_idle();
        repeat (1200) @(posedge clk);

        $display("ran %0d requests: %0d steps, %0d accepts, %0d no-rule halts, %0d overflows",
                 shadow.n_requests, shadow.n_steps, shadow.n_accepts, shadow.n_halts,
                 shadow.n_overflows);
        $display("covered edge growth, a full tape, a long rule scan and several settings; %0d %s",
                 shadow.mismatches, "mismatches");
        if (shadow.mismatches == 0 && shadow.expected_replies.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
design/tmse_pkg.sv
design/tmse_rule_unit.sv
design/tmse_tape_ram.sv
design/turing_machine_step_engine.sv
bench/turing_machine_step_engine_tb.sv
